FILE: rtl/pecb_pkg.sv
// pecb_pkg: shared types and codes for the per-endpoint circuit breaker
// used by the front, back and top-level modules; no dependencies
`timescale 1ns / 1ps
package pecb_pkg;

  localparam logic [2:0] FN_ADMIT   = 3'd0;
  localparam logic [2:0] FN_SUCCESS = 3'd1;
  localparam logic [2:0] FN_FAILURE = 3'd2;
  localparam logic [2:0] FN_CLEAR   = 3'd3;
  localparam logic [2:0] FN_CLR_ALL = 3'd4;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  localparam logic [2:0] REG_COOLDOWN = 3'd0;
  localparam logic [2:0] REG_TRIAL    = 3'd1;
  localparam logic [2:0] REG_RUN      = 3'd2;
  localparam logic [2:0] REG_FLOOR    = 3'd3;
  localparam logic [2:0] REG_ERRFRAC  = 3'd4;
  localparam logic [2:0] REG_LATLIM   = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] opened_time;
    logic [15:0] trial_count;
    logic [31:0] calls;
    logic [31:0] failures;
    logic [15:0] failure_run;
    logic [55:0] latency_sum;
  } entry_t;

  typedef struct packed {
    logic [31:0] cooldown_time;
    logic [15:0] trial_limit;
    logic [15:0] failure_run_limit;
    logic [31:0] sample_floor;
    logic [16:0] error_fraction;
    logic [23:0] latency_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  endpoint;
    logic [47:0] now_time;
    logic [23:0] latency;
    logic        in_range;
  } item_t;

endpackage

FILE: rtl/pecb_ram.sv
// pecb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
module pecb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pecb_front.sv
// pecb_front: accepts input transfers, checks the endpoint range and
// queues items for the back end (two-entry queue); uses pecb_pkg
`timescale 1ns / 1ps
module pecb_front #(
  parameter int ENDPOINTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           func,
  input  logic [5:0]           endpoint,
  input  logic [47:0]          now_time,
  input  logic [23:0]          latency,
  output logic                 q_valid,
  output pecb_pkg::item_t      q_item,
  input  logic                 q_pop
);

  pecb_pkg::item_t slot [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;
  logic            push;
  pecb_pkg::item_t item_in;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    item_in.func     = func;
    item_in.endpoint = endpoint;
    item_in.now_time = now_time;
    item_in.latency  = latency;
    item_in.in_range = (32'(endpoint) < 32'(ENDPOINTS));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/pecb_back.sv
// pecb_back: read-modify-write of one endpoint entry per item, threshold
// multiplies and the result register; uses pecb_pkg and pecb_ram
`timescale 1ns / 1ps
module pecb_back #(
  parameter int ENDPOINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  pecb_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  pecb_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            allowed,
  output logic [1:0]      circuit_state,
  output logic [31:0]     call_total,
  output logic [31:0]     error_total
);

  // only 64 endpoints are reachable through a 6-bit index
  localparam int DEPTH = (ENDPOINTS < 64) ? ENDPOINTS : 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = $bits(pecb_pkg::entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state;
  pecb_pkg::item_t  cur;
  logic [DEPTH-1:0] vld;
  logic [EW-1:0]    rdata;
  logic [AW-1:0]    idx;

  pecb_pkg::entry_t ent;
  pecb_pkg::entry_t upd;
  logic             allow_c;
  logic [47:0]      elapsed;
  logic [56:0]      lsum_add;

  pecb_pkg::entry_t nxt;
  logic             nxt_allow;
  logic             is_fail;
  logic             force_trip;
  logic             floor_ok;
  logic             do_write;
  logic [48:0]      prod_err;
  logic [55:0]      prod_lat;

  logic             trip;
  logic             slot_free;
  pecb_pkg::entry_t fin;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign idx       = cur.endpoint[AW-1:0];
  assign slot_free = !out_valid || !out_stall;

  pecb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (state == S_FIN && slot_free && do_write),
    .waddr (idx),
    .wdata (fin),
    .raddr (q_item.endpoint[AW-1:0]),
    .rdata (rdata)
  );

  // entry update, less the trip decision
  always_comb begin
    ent      = vld[idx] ? pecb_pkg::entry_t'(rdata) : '0;
    upd      = ent;
    allow_c  = 1'b0;
    elapsed  = cur.now_time - ent.opened_time;
    lsum_add = {1'b0, ent.latency_sum} + 57'(cur.latency);
    unique case (cur.func)
      pecb_pkg::FN_ADMIT: begin
        if (ent.mode == pecb_pkg::MODE_CLOSED) begin
          allow_c = 1'b1;
        end else begin
          if (ent.mode == pecb_pkg::MODE_OPEN && elapsed >= 48'(cfg.cooldown_time)) begin
            upd.mode        = pecb_pkg::MODE_HALF;
            upd.trial_count = '0;
          end
          if (upd.mode == pecb_pkg::MODE_HALF && upd.trial_count < cfg.trial_limit) begin
            upd.trial_count = upd.trial_count + 16'd1;
            allow_c         = 1'b1;
          end
        end
      end
      pecb_pkg::FN_SUCCESS: begin
        upd.calls       = (&ent.calls) ? ent.calls : ent.calls + 32'd1;
        upd.latency_sum = lsum_add[56] ? {56{1'b1}} : lsum_add[55:0];
        upd.failure_run = '0;
        if (ent.mode == pecb_pkg::MODE_HALF) begin
          upd.mode = pecb_pkg::MODE_CLOSED;
        end
      end
      pecb_pkg::FN_FAILURE: begin
        upd.calls       = (&ent.calls) ? ent.calls : ent.calls + 32'd1;
        upd.failures    = (&ent.failures) ? ent.failures : ent.failures + 32'd1;
        upd.failure_run = (&ent.failure_run) ? ent.failure_run : ent.failure_run + 16'd1;
      end
      pecb_pkg::FN_CLEAR: begin
        upd = '0;
      end
      default: begin
        upd = ent;
      end
    endcase
    if (!cur.in_range || cur.func == pecb_pkg::FN_CLR_ALL) begin
      upd     = '0;
      allow_c = 1'b0;
    end
  end

  always_comb begin
    trip = is_fail && (force_trip || (floor_ok &&
           ((49'({nxt.failures, 16'd0}) >= prod_err) || (nxt.latency_sum >= prod_lat))));
    fin = nxt;
    if (trip) begin
      fin.mode        = pecb_pkg::MODE_OPEN;
      fin.opened_time = cur.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_READ) begin
      nxt        <= upd;
      nxt_allow  <= allow_c;
      is_fail    <= cur.in_range && cur.func == pecb_pkg::FN_FAILURE;
      force_trip <= (ent.mode != pecb_pkg::MODE_CLOSED) ||
                    (upd.failure_run >= cfg.failure_run_limit);
      floor_ok   <= upd.calls >= cfg.sample_floor;
      do_write   <= cur.in_range && cur.func <= pecb_pkg::FN_CLEAR;
      prod_err   <= 49'(cfg.error_fraction) * 49'(upd.calls);
      prod_lat   <= 56'(cfg.latency_limit) * 56'(upd.calls);
    end
    if (state == S_FIN && slot_free) begin
      allowed       <= nxt_allow;
      circuit_state <= fin.mode;
      call_total    <= fin.calls;
      error_total   <= fin.failures;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (cur.func == pecb_pkg::FN_CLR_ALL) begin
              vld <= '0;
            end else if (do_write) begin
              vld[idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/per_endpoint_circuit_breaker.sv
// per_endpoint_circuit_breaker: top level, configuration registers and the
// front queue feeding the table back end; uses pecb_pkg, pecb_front, pecb_back
`timescale 1ns / 1ps
// Each item passes through the back end in order: a table read, an update
// step with the two threshold multiplies, and a write-back step that loads
// the result register and waits while the result register is stalled. A
// two-entry queue in front takes new transfers while the back end works.
// Endpoint state is cleared at reset and by clear-all through per-entry
// valid bits, so no clearing pass is needed.
module per_endpoint_circuit_breaker #(
  parameter int ENDPOINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [5:0]  endpoint,
  input  logic [47:0] now_time,
  input  logic [23:0] latency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        allowed,
  output logic [1:0]  circuit_state,
  output logic [31:0] call_total,
  output logic [31:0] error_total
);

  pecb_pkg::cfg_t  cfg;
  logic            q_valid;
  pecb_pkg::item_t q_item;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooldown_time     <= 32'd1000000;
      cfg.trial_limit       <= 16'd1;
      cfg.failure_run_limit <= 16'd5;
      cfg.sample_floor      <= 32'd20;
      cfg.error_fraction    <= 17'd32768;
      cfg.latency_limit     <= 24'd1000000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pecb_pkg::REG_COOLDOWN: cfg.cooldown_time     <= cfg_data;
        pecb_pkg::REG_TRIAL:    cfg.trial_limit       <= cfg_data[15:0];
        pecb_pkg::REG_RUN:      cfg.failure_run_limit <= cfg_data[15:0];
        pecb_pkg::REG_FLOOR:    cfg.sample_floor      <= cfg_data;
        pecb_pkg::REG_ERRFRAC:  cfg.error_fraction    <= cfg_data[16:0];
        pecb_pkg::REG_LATLIM:   cfg.latency_limit     <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  pecb_front #(.ENDPOINTS(ENDPOINTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .endpoint (endpoint),
    .now_time (now_time),
    .latency  (latency),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pecb_back #(.ENDPOINTS(ENDPOINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .allowed       (allowed),
    .circuit_state (circuit_state),
    .call_total    (call_total),
    .error_total   (error_total)
  );

endmodule

FILE: verif/pecb_checker.sv
// pecb_checker: watches the config port and both channels of the circuit breaker,
// keeps its own copy of the endpoint table and compares every result transfer
`timescale 1ns / 1ps
module pecb_checker #(
  parameter int ENDPOINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  func,
  input  logic [5:0]  endpoint,
  input  logic [47:0] now_time,
  input  logic [23:0] latency,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        allowed,
  input  logic [1:0]  circuit_state,
  input  logic [31:0] call_total,
  input  logic [31:0] error_total,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic        allowed;
    logic [1:0]  state;
    logic [31:0] calls;
    logic [31:0] errors;
  } outcome_t;

  pecb_pkg::entry_t book[ENDPOINTS];
  pecb_pkg::cfg_t   regs;
  outcome_t         awaited[$];

  function automatic logic [31:0] inc32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  // updates the table copy and returns the result the block owes
  function automatic outcome_t breaker_step(logic [2:0] fn, logic [5:0] ep,
                                            logic [47:0] now, logic [23:0] lat);
    pecb_pkg::entry_t e;
    logic             ok;
    logic [47:0]      elapsed;
    logic [56:0]      sum;
    logic [63:0]      err_lhs, err_rhs, lat_rhs;
    outcome_t         res;
    ok = 1'b0;
    if (fn == pecb_pkg::FN_CLR_ALL) begin
      for (int i = 0; i < ENDPOINTS; i++) book[i] = '0;
      return '0;
    end
    if (int'(ep) >= ENDPOINTS) return '0;
    e = book[ep];
    case (fn)
      pecb_pkg::FN_ADMIT: begin
        if (e.mode == pecb_pkg::MODE_CLOSED) begin
          ok = 1'b1;
        end else begin
          if (e.mode == pecb_pkg::MODE_OPEN) begin
            elapsed = now - e.opened_time;
            if (elapsed >= {16'd0, regs.cooldown_time}) begin
              e.mode = pecb_pkg::MODE_HALF;
              e.trial_count = '0;
            end
          end
          if (e.mode == pecb_pkg::MODE_HALF && e.trial_count < regs.trial_limit) begin
            e.trial_count = inc16(e.trial_count);
            ok = 1'b1;
          end
        end
      end
      pecb_pkg::FN_SUCCESS: begin
        e.calls = inc32(e.calls);
        sum = {1'b0, e.latency_sum} + {33'd0, lat};
        e.latency_sum = sum[56] ? '1 : sum[55:0];
        e.failure_run = '0;
        if (e.mode == pecb_pkg::MODE_HALF) e.mode = pecb_pkg::MODE_CLOSED;
      end
      pecb_pkg::FN_FAILURE: begin
        e.calls = inc32(e.calls);
        e.failures = inc32(e.failures);
        e.failure_run = inc16(e.failure_run);
        err_lhs = {16'd0, e.failures, 16'd0};
        err_rhs = 64'(regs.error_fraction) * 64'(e.calls);
        lat_rhs = 64'(regs.latency_limit) * 64'(e.calls);
        if (e.mode != pecb_pkg::MODE_CLOSED || e.failure_run >= regs.failure_run_limit ||
            (e.calls >= regs.sample_floor &&
             (err_lhs >= err_rhs || 64'(e.latency_sum) >= lat_rhs))) begin
          e.mode = pecb_pkg::MODE_OPEN;
          e.opened_time = now;
        end
      end
      pecb_pkg::FN_CLEAR: e = '0;
      default: ;
    endcase
    book[ep] = e;
    res.allowed = ok;
    res.state = e.mode;
    res.calls = e.calls;
    res.errors = e.failures;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENDPOINTS; i++) book[i] = '0;
      regs.cooldown_time = 32'd1000000;
      regs.trial_limit = 16'd1;
      regs.failure_run_limit = 16'd5;
      regs.sample_floor = 32'd20;
      regs.error_fraction = 17'd32768;
      regs.latency_limit = 24'd1000000;
      awaited.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pecb_pkg::REG_COOLDOWN: regs.cooldown_time = cfg_data;
          pecb_pkg::REG_TRIAL:    regs.trial_limit = cfg_data[15:0];
          pecb_pkg::REG_RUN:      regs.failure_run_limit = cfg_data[15:0];
          pecb_pkg::REG_FLOOR:    regs.sample_floor = cfg_data;
          pecb_pkg::REG_ERRFRAC:  regs.error_fraction = cfg_data[16:0];
          pecb_pkg::REG_LATLIM:   regs.latency_limit = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: result transfer with nothing expected (state %0d calls %0d)",
                   $time, circuit_state, call_total);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (allowed !== want.allowed) begin
            $display("%0t: allowed expected %0d actual %0d", $time, want.allowed, allowed);
            mismatches++;
          end
          if (circuit_state !== want.state) begin
            $display("%0t: circuit_state expected %0d actual %0d",
                     $time, want.state, circuit_state);
            mismatches++;
          end
          if (call_total !== want.calls) begin
            $display("%0t: call_total expected %0d actual %0d", $time, want.calls, call_total);
            mismatches++;
          end
          if (error_total !== want.errors) begin
            $display("%0t: error_total expected %0d actual %0d",
                     $time, want.errors, error_total);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited.push_back(breaker_step(func, endpoint, now_time, latency));
    end
    pending = awaited.size();
  end

endmodule

FILE: verif/testbench.sv
// testbench: drives the per-endpoint circuit breaker with directed and random calls
// across several register settings; depends on pecb_pkg, per_endpoint_circuit_breaker and pecb_checker
`timescale 1ns / 1ps
module testbench;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  logic [5:0]  endpoint;
  logic [47:0] now_time;
  logic [23:0] latency;
  logic        out_valid;
  logic        out_stall;
  logic        allowed;
  logic [1:0]  circuit_state;
  logic [31:0] call_total;
  logic [31:0] error_total;

  int          mismatches;
  int          pending;
  bit          quiet;
  bit          long_hold;
  int          idle_cycles;
  logic [47:0] now_us;

  per_endpoint_circuit_breaker dut (.*);

  pecb_checker watch (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    wait (idle_cycles >= 3000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_call(logic [2:0] fn, logic [5:0] ep, logic [47:0] now,
                           logic [23:0] lat);
    in_valid <= 1'b1;
    func <= fn;
    endpoint <= ep;
    now_time <= now;
    latency <= lat;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] cool, logic [15:0] trial, logic [15:0] run,
                              logic [31:0] floor_calls, logic [16:0] frac,
                              logic [23:0] lat_lim);
    logic [31:0] vals[6];
    vals = '{cool, 32'(trial), 32'(run), floor_calls, 32'(frac), 32'(lat_lim)};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_calls(int count);
    logic [2:0]  fn;
    logic [5:0]  ep;
    logic [23:0] lat;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      fn = pecb_pkg::FN_ADMIT;
      else if (pick < 65) fn = pecb_pkg::FN_SUCCESS;
      else if (pick < 90) fn = pecb_pkg::FN_FAILURE;
      else if (pick < 94) fn = pecb_pkg::FN_CLEAR;
      else if (pick < 96) fn = pecb_pkg::FN_CLR_ALL;
      else                fn = 3'($urandom_range(5, 7));
      ep = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 5)) : 6'($urandom);
      lat = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
      // mostly small steps so cooldowns expire; rare jumps anywhere, wrap included
      if ($urandom_range(0, 15) == 0) now_us = {16'($urandom), 32'($urandom)};
      else now_us = now_us + 48'($urandom_range(0, 40));
      send_call(fn, ep, now_us, lat);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = '0;
    endpoint = '0;
    now_time = '0;
    latency = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: run-limit trip, cooldown, half-open trial, reopen, clears, odd codes
    now_us = 48'd100;
    send_call(pecb_pkg::FN_ADMIT, 6'd0, now_us, 24'd0);
    for (int i = 0; i < 5; i++) send_call(pecb_pkg::FN_FAILURE, 6'd0, now_us, 24'd0);
    send_call(pecb_pkg::FN_ADMIT, 6'd0, now_us + 48'd999999, 24'd0);
    send_call(pecb_pkg::FN_ADMIT, 6'd0, now_us + 48'd1000000, 24'd0);
    send_call(pecb_pkg::FN_ADMIT, 6'd0, now_us + 48'd1000001, 24'd0);
    send_call(pecb_pkg::FN_SUCCESS, 6'd0, now_us, 24'hFFFFFF);
    for (int i = 0; i < 5; i++) send_call(pecb_pkg::FN_FAILURE, 6'd0, now_us, 24'd0);
    send_call(pecb_pkg::FN_ADMIT, 6'd0, now_us + 48'd2000000, 24'd0);
    send_call(pecb_pkg::FN_FAILURE, 6'd0, now_us + 48'd2000000, 24'd0);
    send_call(pecb_pkg::FN_SUCCESS, 6'd0, now_us, 24'd5);
    send_call(pecb_pkg::FN_FAILURE, 6'd63, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF);
    for (int i = 0; i < 4; i++)
      send_call(pecb_pkg::FN_FAILURE, 6'd63, 48'hFFFF_FFFF_FFFF, 24'd0);
    send_call(pecb_pkg::FN_ADMIT, 6'd63, 48'd999999, 24'd0);
    send_call(pecb_pkg::FN_CLEAR, 6'd0, now_us, 24'd0);
    send_call(3'd5, 6'd63, now_us, 24'hABCDEF);
    send_call(3'd6, 6'd63, now_us, 24'd0);
    send_call(3'd7, 6'd63, now_us, 24'd0);
    send_call(pecb_pkg::FN_CLR_ALL, 6'd63, now_us, 24'd0);
    settle();

    program_regs(32'd50, 16'd2, 16'd3, 32'd8, 17'd32768, 24'd5000);
    long_hold = 1'b1;
    random_calls(240);
    settle();
    program_regs(32'd0, 16'd0, 16'd0, 32'd0, 17'd0, 24'd0);
    random_calls(240);
    settle();
    program_regs(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 17'd65536, 24'hFFFFFF);
    random_calls(240);
    settle();
    program_regs(32'd20, 16'd1, 16'hFFFF, 32'd4, 17'd16384, 24'hFFFFFF);
    random_calls(240);
    settle();
    program_regs(32'd10, 16'd3, 16'd4, 32'd12, 17'd65536, 24'd800000);
    random_calls(240);
    settle();
    program_regs(32'($urandom_range(0, 60)), 16'($urandom_range(0, 4)),
                 16'($urandom_range(0, 8)), 32'($urandom_range(0, 30)),
                 17'($urandom_range(0, 65536)), 24'($urandom_range(0, 4000)));
    quiet = 1'b1;
    random_calls(240);
    settle();

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pecb_pkg.sv
rtl/pecb_ram.sv
rtl/pecb_front.sv
rtl/pecb_back.sv
rtl/per_endpoint_circuit_breaker.sv
verif/pecb_checker.sv
verif/testbench.sv
